// ===== hw/rtl/pgm_p5_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgm_p5_pkg: shared types and constants of the P5 graymap deframer
// Payload structs, the parser phase enum, result kinds and the command
// format that travels from the parser front to the result back end.
// ----------------------------------------------------------------------------
package pgm_p5_pkg;

	localparam int FIELD_W    = 13;  // width of run length and dimension fields
	localparam int PIX_W      = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PTR_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BORDER_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN_SHADE  = 1'd1;

	typedef enum logic [1:0] {
		KIND_DIMS = 2'd0,
		KIND_RUN  = 2'd1,
		KIND_ERR  = 2'd2,
		KIND_MAXV = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		PH_WAIT_P  = 4'd0,
		PH_WAIT_5  = 4'd1,
		PH_SKIP    = 4'd2,
		PH_COMMENT = 4'd3,
		PH_WIDTH   = 4'd4,
		PH_GAP1    = 4'd5,
		PH_HEIGHT  = 4'd6,
		PH_GAP2    = 4'd7,
		PH_MAXV    = 4'd8,
		PH_PIX     = 4'd9,
		PH_HALT    = 4'd10
	} phase_t;

	typedef struct packed {
		logic [PIX_W-1:0] data_byte;
		logic             frame_start;
	} in_item_t;

	typedef struct packed {
		kind_t              out_kind;
		logic [PIX_W-1:0]   pixel_value;
		logic [FIELD_W-1:0] run_length;
		logic [FIELD_W-1:0] image_width;
		logic [FIELD_W-1:0] image_height;
		logic               last;
	} res_item_t;

	// One parsed event. KIND_RUN marks a pixel byte.
	typedef struct packed {
		kind_t              kind;
		logic [PIX_W-1:0]   value;
		logic [PIX_W-1:0]   margin;
		logic [FIELD_W-1:0] width;
		logic [FIELD_W-1:0] height;
		logic               border;
		logic               left;   // margin pixel before this pixel
		logic               right;  // margin pixel after this pixel
		logic               fin;    // last pixel of the image
	} cmd_t;

endpackage

// ===== hw/rtl/pgm_p5_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgm_p5_front: header parser and pixel classifier
// Takes one file byte per transaction, walks the P5 header and turns every
// byte that causes output into one command for the back end.
// ----------------------------------------------------------------------------
module pgm_p5_front #(
	parameter int MAX_DIM = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  byte_valid,
	input  pgm_p5_pkg::in_item_t                  byte_item,
	output logic                                  byte_stall,
	input  logic                                  cfg_valid,
	input  logic [pgm_p5_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pgm_p5_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                  q_full,
	output logic                                  q_push,
	output pgm_p5_pkg::cmd_t                      q_cmd
);

	localparam int DW_RAW = $clog2(MAX_DIM + 1);
	// a lone first digit is stored unchecked, so keep room for 9
	localparam int DW = (DW_RAW < 4) ? 4 : DW_RAW;
	localparam int VW = DW + 4;

	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_5    = 8'h35;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_VT   = 8'h0B;
	localparam logic [7:0] CH_FF   = 8'h0C;
	localparam logic [7:0] CH_CR   = 8'h0D;

	function automatic logic is_sep(input logic [7:0] c);
		return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return is_sep(c) || (c == CH_VT) || (c == CH_FF);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	pgm_p5_pkg::phase_t phase_q, phase_d, phase_cur;
	logic [DW-1:0] acc_q, acc_d;
	logic [DW-1:0] width_q, width_d;
	logic [DW-1:0] height_q, height_d;
	logic [DW-1:0] col_q, col_d;
	logic [DW-1:0] row_q, row_d;
	logic          border_enable_q;
	logic [7:0]    margin_shade_q;
	logic          frame_border_q;
	logic [7:0]    frame_margin_q;
	logic          latch_frame;

	logic          accept;
	logic [7:0]    c;
	logic [VW-1:0] acc_next;
	logic          acc_ovf;
	logic [DW-1:0] col_inc, row_inc;
	logic          eol, fin;

	assign byte_stall = q_full;
	assign accept     = byte_valid && !byte_stall;
	assign c          = byte_item.data_byte;

	// acc * 10 + digit as two shifts and two adds
	assign acc_next = VW'({acc_q, 3'b000}) + VW'({acc_q, 1'b0}) + VW'(c[3:0]);
	assign acc_ovf  = acc_next > VW'(MAX_DIM);
	assign col_inc  = col_q + DW'(1);
	assign row_inc  = row_q + DW'(1);
	assign eol      = col_inc >= width_q;
	assign fin      = eol && (row_inc >= height_q);

	always_comb begin
		phase_cur   = byte_item.frame_start ? pgm_p5_pkg::PH_WAIT_P : phase_q;
		phase_d     = phase_q;
		acc_d       = acc_q;
		width_d     = width_q;
		height_d    = height_q;
		col_d       = col_q;
		row_d       = row_q;
		latch_frame = 1'b0;
		q_push      = 1'b0;
		q_cmd       = '0;
		q_cmd.kind  = pgm_p5_pkg::KIND_ERR;
		if (accept) begin
			phase_d = phase_cur;
			unique case (phase_cur)
				pgm_p5_pkg::PH_WAIT_P: begin
					if (c != CH_P) begin
						q_push  = 1'b1;
						phase_d = pgm_p5_pkg::PH_HALT;
					end else begin
						phase_d = pgm_p5_pkg::PH_WAIT_5;
					end
				end
				pgm_p5_pkg::PH_WAIT_5: begin
					if (c != CH_5) begin
						q_push  = 1'b1;
						phase_d = pgm_p5_pkg::PH_HALT;
					end else begin
						phase_d = pgm_p5_pkg::PH_SKIP;
					end
				end
				pgm_p5_pkg::PH_SKIP, pgm_p5_pkg::PH_GAP1, pgm_p5_pkg::PH_GAP2: begin
					if (phase_cur == pgm_p5_pkg::PH_SKIP && c == CH_HASH) begin
						phase_d = pgm_p5_pkg::PH_COMMENT;
					end else if (is_space(c)) begin
						phase_d = phase_cur;
					end else if (!is_digit(c)) begin
						q_push  = 1'b1;
						phase_d = pgm_p5_pkg::PH_HALT;
					end else begin
						acc_d = DW'(c[3:0]);
						if (phase_cur == pgm_p5_pkg::PH_SKIP)
							phase_d = pgm_p5_pkg::PH_WIDTH;
						else if (phase_cur == pgm_p5_pkg::PH_GAP1)
							phase_d = pgm_p5_pkg::PH_HEIGHT;
						else
							phase_d = pgm_p5_pkg::PH_MAXV;
					end
				end
				pgm_p5_pkg::PH_COMMENT: begin
					if (c == CH_CR || c == CH_LF)
						phase_d = pgm_p5_pkg::PH_SKIP;
				end
				pgm_p5_pkg::PH_WIDTH, pgm_p5_pkg::PH_HEIGHT: begin
					if (is_digit(c)) begin
						if (acc_ovf) begin
							q_push  = 1'b1;
							phase_d = pgm_p5_pkg::PH_HALT;
						end else begin
							acc_d = acc_next[DW-1:0];
						end
					end else if (!is_space(c) || acc_q == '0) begin
						q_push  = 1'b1;
						phase_d = pgm_p5_pkg::PH_HALT;
					end else if (phase_cur == pgm_p5_pkg::PH_WIDTH) begin
						width_d = acc_q;
						phase_d = pgm_p5_pkg::PH_GAP1;
					end else begin
						height_d = acc_q;
						phase_d  = pgm_p5_pkg::PH_GAP2;
					end
				end
				pgm_p5_pkg::PH_MAXV: begin
					if (is_digit(c)) begin
						if (acc_ovf) begin
							q_push  = 1'b1;
							phase_d = pgm_p5_pkg::PH_HALT;
						end else begin
							acc_d = acc_next[DW-1:0];
						end
					end else if (32'(acc_q) != 32'd255) begin
						// maxval is judged before the separator
						q_push     = 1'b1;
						q_cmd.kind = pgm_p5_pkg::KIND_MAXV;
						phase_d    = pgm_p5_pkg::PH_HALT;
					end else if (!is_sep(c)) begin
						q_push  = 1'b1;
						phase_d = pgm_p5_pkg::PH_HALT;
					end else begin
						latch_frame  = 1'b1;
						col_d        = '0;
						row_d        = '0;
						phase_d      = pgm_p5_pkg::PH_PIX;
						q_push       = 1'b1;
						q_cmd.kind   = pgm_p5_pkg::KIND_DIMS;
						q_cmd.width  = pgm_p5_pkg::FIELD_W'(width_q);
						q_cmd.height = pgm_p5_pkg::FIELD_W'(height_q);
						q_cmd.border = border_enable_q;
						q_cmd.margin = margin_shade_q;
					end
				end
				pgm_p5_pkg::PH_PIX: begin
					q_push       = 1'b1;
					q_cmd.kind   = pgm_p5_pkg::KIND_RUN;
					q_cmd.value  = c;
					q_cmd.margin = frame_margin_q;
					q_cmd.width  = pgm_p5_pkg::FIELD_W'(width_q);
					q_cmd.border = frame_border_q;
					q_cmd.left   = frame_border_q && (col_q == '0);
					q_cmd.right  = frame_border_q && eol;
					q_cmd.fin    = fin;
					col_d        = eol ? '0 : col_inc;
					row_d        = eol ? row_inc : row_q;
					if (fin)
						phase_d = pgm_p5_pkg::PH_HALT;
				end
				pgm_p5_pkg::PH_HALT: begin
					phase_d = pgm_p5_pkg::PH_HALT;
				end
				default: begin
					phase_d = pgm_p5_pkg::PH_HALT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= pgm_p5_pkg::PH_WAIT_P;
			acc_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			acc_q    <= acc_d;
			width_q  <= width_d;
			height_q <= height_d;
			col_q    <= col_d;
			row_q    <= row_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			border_enable_q <= 1'b0;
			margin_shade_q  <= 8'hFF;
			frame_border_q  <= 1'b0;
			frame_margin_q  <= 8'hFF;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					pgm_p5_pkg::REG_BORDER_ENABLE: border_enable_q <= cfg_data[0];
					pgm_p5_pkg::REG_MARGIN_SHADE:  margin_shade_q  <= cfg_data;
					default: ;
				endcase
			end
			if (latch_frame) begin
				frame_border_q <= border_enable_q;
				frame_margin_q <= margin_shade_q;
			end
		end
	end

endmodule

// ===== hw/rtl/pgm_p5_cmdq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgm_p5_cmdq: command queue between parser and result back end
// Small register FIFO; the head entry is visible without a pop.
// ----------------------------------------------------------------------------
module pgm_p5_cmdq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pgm_p5_pkg::cmd_t push_cmd,
	input  logic             pop,
	output pgm_p5_pkg::cmd_t head,
	output logic             empty,
	output logic             full
);

	localparam int PW = pgm_p5_pkg::CMDQ_PTR_W;

	pgm_p5_pkg::cmd_t mem_q [pgm_p5_pkg::CMDQ_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;

	assign empty = count_q == '0;
	assign full  = count_q == (PW+1)'(pgm_p5_pkg::CMDQ_DEPTH);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + (PW+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (PW+1)'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("cmdq push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("cmdq pop while empty");

endmodule

// ===== hw/rtl/pgm_p5_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgm_p5_back: result sequencer
// Expands the queue head into one to four results, one per cycle unless
// res_stall holds the output, through a registered output stage.
// ----------------------------------------------------------------------------
module pgm_p5_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pgm_p5_pkg::cmd_t      q_head,
	input  logic                  q_empty,
	output logic                  q_pop,
	output logic                  res_valid,
	output pgm_p5_pkg::res_item_t res_item,
	input  logic                  res_stall
);

	logic                  busy_q;
	logic [3:0]            mask_q;
	logic [3:0]            mask_head, mask_cur, low, rem;
	logic [1:0]            slot;
	logic                  have, load, emit;
	logic                  res_valid_q;
	pgm_p5_pkg::res_item_t res_item_q;
	pgm_p5_pkg::res_item_t res_d;
	logic [pgm_p5_pkg::FIELD_W-1:0] row_run;

	// slot 0: left margin / dims / error, 1: pixel / top row,
	// 2: right margin, 3: bottom row
	always_comb begin
		case (q_head.kind)
			pgm_p5_pkg::KIND_RUN:
				mask_head = {q_head.fin && q_head.border, q_head.right, 1'b1, q_head.left};
			pgm_p5_pkg::KIND_DIMS:
				mask_head = {2'b00, q_head.border, 1'b1};
			default:
				mask_head = 4'b0001;
		endcase
	end

	assign mask_cur = busy_q ? mask_q : mask_head;
	assign low      = mask_cur & (~mask_cur + 4'd1);
	assign rem      = mask_cur & ~low;
	assign have     = busy_q || !q_empty;
	assign load     = !res_valid_q || !res_stall;
	assign emit     = load && have;
	assign q_pop    = emit && (rem == 4'b0000);
	assign row_run  = q_head.width + pgm_p5_pkg::FIELD_W'(2);

	always_comb begin
		if (mask_cur[0])
			slot = 2'd0;
		else if (mask_cur[1])
			slot = 2'd1;
		else if (mask_cur[2])
			slot = 2'd2;
		else
			slot = 2'd3;
	end

	always_comb begin
		res_d             = '0;
		res_d.out_kind    = pgm_p5_pkg::KIND_RUN;
		res_d.pixel_value = q_head.margin;
		res_d.run_length  = pgm_p5_pkg::FIELD_W'(1);
		unique case (slot)
			2'd0: begin
				if (q_head.kind == pgm_p5_pkg::KIND_DIMS) begin
					res_d.out_kind     = pgm_p5_pkg::KIND_DIMS;
					res_d.pixel_value  = '0;
					res_d.run_length   = '0;
					res_d.image_width  = q_head.width;
					res_d.image_height = q_head.height;
				end else if (q_head.kind != pgm_p5_pkg::KIND_RUN) begin
					res_d.out_kind    = q_head.kind;
					res_d.pixel_value = '0;
					res_d.run_length  = '0;
					res_d.last        = 1'b1;
				end
			end
			2'd1: begin
				if (q_head.kind == pgm_p5_pkg::KIND_DIMS) begin
					res_d.run_length = row_run;
				end else begin
					res_d.pixel_value = q_head.value;
					res_d.last        = q_head.fin && !q_head.border;
				end
			end
			2'd2: ;
			2'd3: begin
				res_d.run_length = row_run;
				res_d.last       = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			mask_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				busy_q <= rem != 4'b0000;
				mask_q <= rem;
			end
			if (load)
				res_valid_q <= have;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			res_item_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	a_busy_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !q_empty)
		else $error("back end busy without a queued command");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_item_q.out_kind == pgm_p5_pkg::KIND_ERR ||
			res_item_q.out_kind == pgm_p5_pkg::KIND_MAXV)) |-> res_item_q.last)
		else $error("error result without last");

endmodule

// ===== hw/rtl/pgm_p5_stream_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgm_p5_stream_deframer: binary graymap (P5) byte stream parser
// Parses the P5 header, reports the dimensions and streams pixels as runs,
// with an optional one-pixel margin around the image.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle while byte_stall is low; the result
// side emits one result per cycle while res_stall is low, so a pixel that
// opens or closes a row with the border on yields two or three results,
// the final one up to four, and the header's end two. A four-entry command
// queue between the parser and the result sequencer soaks up those bursts;
// when it fills, byte_stall rises until the sequencer catches up. Results
// leave through a registered stage; a stalled result holds the sequencer,
// and the parser keeps taking bytes until the queue fills. frame_start on a
// byte restarts parsing with that byte as the first of a new file.
// Configuration is taken at any time (cfg_ready is always high); the border
// enable and the margin shade register are sampled when a header completes
// and hold for that frame.
// ----------------------------------------------------------------------------
module pgm_p5_stream_deframer #(
	parameter int MAX_DIM = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// byte input channel
	input  logic                               byte_valid,
	input  pgm_p5_pkg::in_item_t               byte_item,
	output logic                               byte_stall,
	// result output channel
	output logic                               res_valid,
	output pgm_p5_pkg::res_item_t              res_item,
	input  logic                               res_stall,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pgm_p5_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pgm_p5_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// queue between parser and sequencer
	logic             q_push, q_pop, q_empty, q_full;
	pgm_p5_pkg::cmd_t q_cmd, q_head;

	assign cfg_ready = 1'b1;

	// front: header state machine, pixel position counters, config registers
	pgm_p5_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_item  (byte_item),
		.byte_stall (byte_stall),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_cmd)
	);

	pgm_p5_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	// back: each command becomes one to four result transactions
	pgm_p5_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_head    (q_head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_item  (res_item),
		.res_stall (res_stall)
	);

endmodule

// ===== dv/tb_pgm_p5_stream_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pgm_p5_stream_deframer: self-checking bench for the P5 graymap deframer
// Streams clean and damaged graymap files plus raw noise into the byte port
// under random idle and stall. A bench-side parser predicts every result
// transaction, and each accepted result is compared field by field.
// ----------------------------------------------------------------------------
module tb_pgm_p5_stream_deframer;
	import pgm_p5_pkg::*;

	localparam int MAX_DIM     = 4096;
	localparam int DRAIN       = 40;      // command queue plus output stage, with margin
	localparam int CYCLE_LIMIT = 400000;
	localparam int BATCH_BYTES = 40;

	// byte values the parser cares about
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_5     = 8'h35;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam int unsigned MAXVAL_OK = 255;

	// ways a generated file can be damaged
	typedef enum int {
		FLAW_NONE,
		FLAW_BAD_MAGIC,
		FLAW_SIGN,
		FLAW_OVERSIZE,
		FLAW_ZERO_DIM,
		FLAW_BAD_MAXVAL,
		FLAW_LATE_COMMENT,
		FLAW_VT_AFTER_MAXVAL,
		FLAW_TRUNCATED,
		FLAW_HUGE_HEADER,
		FLAW_NOISE
	} flaw_t;
	localparam int FLAW_KINDS = 10;

	// ------------------------------------------------------------------------
	// DUT hookup; every input has a known value from time zero
	// ------------------------------------------------------------------------
	logic                  clk;
	logic                  arst_n     = 1'b0;
	logic                  byte_valid = 1'b0;
	in_item_t              byte_item  = '0;
	logic                  byte_stall;
	logic                  res_valid;
	res_item_t             res_item;
	logic                  res_stall  = 1'b0;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	pgm_p5_stream_deframer #(.MAX_DIM(MAX_DIM)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_item (byte_item),
		.byte_stall(byte_stall),
		.res_valid (res_valid),
		.res_item  (res_item),
		.res_stall (res_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------------
	// Queues, knobs and counters
	// ------------------------------------------------------------------------
	in_item_t   file_bytes[$];       // bytes waiting for the driver
	res_item_t  graymap_results[$];  // predicted results, oldest first
	logic [7:0] frame_buf[$];        // file under construction

	int src_idle_pct = 0;
	int rcv_idle_pct = 0;

	int cycle_count    = 0;
	int bytes_queued   = 0;
	int bytes_taken    = 0;
	int results_seen   = 0;
	int headers_seen   = 0;
	int format_errors  = 0;
	int maxval_rejects = 0;
	int mismatches     = 0;
	int reg_writes     = 0;
	int flaw_turn      = 0;

	// ------------------------------------------------------------------------
	// Bench-side parser: state after reset, plus register copies
	// ------------------------------------------------------------------------
	phase_t      parse_ph   = PH_WAIT_P;
	int unsigned num_acc    = 0;
	int unsigned img_w      = 0;
	int unsigned img_h      = 0;
	int unsigned col_cnt    = 0;
	int unsigned row_cnt    = 0;
	bit          cfg_border = 1'b0;
	logic [7:0]  cfg_margin = 8'd255;
	bit          frm_border = 1'b0;  // latched at header end, held per frame
	logic [7:0]  frm_margin = 8'd255;

	function automatic bit is_sep(input logic [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic bit is_ws(input logic [7:0] c);
		return is_sep(c) || c == CH_VT || c == CH_FF;
	endfunction

	function automatic bit is_dig(input logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic void emit(input kind_t k, input logic [7:0] pix, input int unsigned run,
			input int unsigned w, input int unsigned h, input bit lst);
		res_item_t r;
		r.out_kind     = k;
		r.pixel_value  = pix;
		r.run_length   = run[FIELD_W-1:0];
		r.image_width  = w[FIELD_W-1:0];
		r.image_height = h[FIELD_W-1:0];
		r.last         = lst;
		graymap_results.push_back(r);
	endfunction

	// error result; the parser then sits until the next frame start
	function automatic void halt_with(input kind_t k);
		parse_ph = PH_HALT;
		emit(k, 8'd0, 0, 0, 0, 1'b1);
	endfunction

	// false when the number would pass MAX_DIM
	function automatic bit add_digit(input logic [7:0] c);
		int unsigned v;
		v = num_acc * 10 + (c - CH_0);
		if (v > MAX_DIM)
			return 1'b0;
		num_acc = v;
		return 1'b1;
	endfunction

	function automatic void parse_byte(input in_item_t it);
		logic [7:0] c;
		bit         fin;
		bit         eol;
		c   = it.data_byte;
		fin = 1'b0;
		eol = 1'b0;
		if (it.frame_start) begin
			parse_ph = PH_WAIT_P;
			num_acc  = 0;
			img_w    = 0;
			img_h    = 0;
			col_cnt  = 0;
			row_cnt  = 0;
		end
		case (parse_ph)
			PH_WAIT_P: begin
				if (c != CH_P)
					halt_with(KIND_ERR);
				else
					parse_ph = PH_WAIT_5;
			end
			PH_WAIT_5: begin
				if (c != CH_5)
					halt_with(KIND_ERR);
				else
					parse_ph = PH_SKIP;
			end
			PH_SKIP, PH_GAP1, PH_GAP2: begin
				// comments are only legal ahead of the width
				if (parse_ph == PH_SKIP && c == CH_HASH) begin
					parse_ph = PH_COMMENT;
				end else if (is_dig(c)) begin
					num_acc = c - CH_0;
					if (parse_ph == PH_SKIP)
						parse_ph = PH_WIDTH;
					else if (parse_ph == PH_GAP1)
						parse_ph = PH_HEIGHT;
					else
						parse_ph = PH_MAXV;
				end else if (!is_ws(c)) begin
					halt_with(KIND_ERR);
				end
			end
			PH_COMMENT: begin
				if (c == CH_CR || c == CH_LF)
					parse_ph = PH_SKIP;
			end
			PH_WIDTH, PH_HEIGHT: begin
				if (is_dig(c)) begin
					if (!add_digit(c))
						halt_with(KIND_ERR);
				end else if (!is_ws(c) || num_acc == 0) begin
					halt_with(KIND_ERR);
				end else if (parse_ph == PH_WIDTH) begin
					img_w    = num_acc;
					parse_ph = PH_GAP1;
				end else begin
					img_h    = num_acc;
					parse_ph = PH_GAP2;
				end
			end
			PH_MAXV: begin
				// maxval is judged before the terminating byte is
				if (is_dig(c)) begin
					if (!add_digit(c))
						halt_with(KIND_ERR);
				end else if (num_acc != MAXVAL_OK) begin
					halt_with(KIND_MAXV);
				end else if (!is_sep(c)) begin
					halt_with(KIND_ERR);
				end else begin
					frm_border = cfg_border;
					frm_margin = cfg_margin;
					col_cnt    = 0;
					row_cnt    = 0;
					parse_ph   = PH_PIX;
					emit(KIND_DIMS, 8'd0, 0, img_w, img_h, 1'b0);
					if (frm_border)
						emit(KIND_RUN, frm_margin, img_w + 2, 0, 0, 1'b0);
				end
			end
			PH_PIX: begin
				if (frm_border && col_cnt == 0)
					emit(KIND_RUN, frm_margin, 1, 0, 0, 1'b0);
				col_cnt++;
				eol = col_cnt >= img_w;
				if (eol) begin
					col_cnt = 0;
					row_cnt++;
					fin = row_cnt >= img_h;
				end
				emit(KIND_RUN, c, 1, 0, 0, fin && !frm_border);
				if (eol && frm_border)
					emit(KIND_RUN, frm_margin, 1, 0, 0, 1'b0);
				if (fin) begin
					if (frm_border)
						emit(KIND_RUN, frm_margin, img_w + 2, 0, 0, 1'b1);
					parse_ph = PH_HALT;
				end
			end
			default: begin
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Clock, reset, cycle limit
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count++;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			graymap_results.size());
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Byte driver: a transaction completes on valid && !stall. A new byte is
	// only presented once the previous one is taken, so valid never follows
	// stall and a stalled byte holds still.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else begin
			if (byte_valid && !byte_stall) begin
				parse_byte(byte_item);
				bytes_taken++;
			end
			if (!byte_valid || !byte_stall) begin
				if (file_bytes.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
					byte_item  <= file_bytes.pop_front();
					byte_valid <= 1'b1;
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor: checks every completed result transaction against the
	// oldest prediction, then picks the stall for the next cycle.
	// ------------------------------------------------------------------------
	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	always @(posedge clk) begin
		res_item_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				results_seen++;
				case (res_item.out_kind)
					KIND_DIMS: headers_seen++;
					KIND_ERR:  format_errors++;
					KIND_MAXV: maxval_rejects++;
					default: begin
					end
				endcase
				if (graymap_results.size() == 0) begin
					flag_mismatch($sformatf("result %0d arrived with none predicted (kind %0d)",
						results_seen, res_item.out_kind));
				end else begin
					want = graymap_results.pop_front();
					if (res_item.out_kind !== want.out_kind)
						flag_mismatch($sformatf("result %0d out_kind %0d, predicted %0d",
							results_seen, res_item.out_kind, want.out_kind));
					if (res_item.pixel_value !== want.pixel_value)
						flag_mismatch($sformatf("result %0d pixel_value %0d, predicted %0d",
							results_seen, res_item.pixel_value, want.pixel_value));
					if (res_item.run_length !== want.run_length)
						flag_mismatch($sformatf("result %0d run_length %0d, predicted %0d",
							results_seen, res_item.run_length, want.run_length));
					if (res_item.image_width !== want.image_width)
						flag_mismatch($sformatf("result %0d image_width %0d, predicted %0d",
							results_seen, res_item.image_width, want.image_width));
					if (res_item.image_height !== want.image_height)
						flag_mismatch($sformatf("result %0d image_height %0d, predicted %0d",
							results_seen, res_item.image_height, want.image_height));
					if (res_item.last !== want.last)
						flag_mismatch($sformatf("result %0d last %0d, predicted %0d",
							results_seen, res_item.last, want.last));
				end
			end
			res_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Helpers for sequencing and config
	// ------------------------------------------------------------------------

	// everything sent, taken and answered, then let the pipeline settle
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (file_bytes.size() != 0 || byte_valid || graymap_results.size() != 0);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_BORDER_ENABLE)
			cfg_border = val[0];
		else if (idx == REG_MARGIN_SHADE)
			cfg_margin = val;
		reg_writes++;
	endtask

	// ------------------------------------------------------------------------
	// File builders
	// ------------------------------------------------------------------------
	task automatic add_byte(input logic [7:0] b);
		frame_buf.push_back(b);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			frame_buf.push_back(s[i]);
	endtask

	// sometimes with a leading zero, which must not change the value
	task automatic add_number(input int unsigned n);
		if ($urandom_range(3) == 0)
			add_byte(CH_0);
		add_text($sformatf("%0d", n));
	endtask

	function automatic logic [7:0] pick_ws(input bit sep_only);
		case ($urandom_range(sep_only ? 3 : 5))
			0:       return CH_SP;
			1:       return CH_TAB;
			2:       return CH_CR;
			3:       return CH_LF;
			4:       return CH_VT;
			default: return CH_FF;
		endcase
	endfunction

	// moves the file into the send queue; scatter drops extra frame starts in
	task automatic ship_frame(input bit lead_start, input bit scatter);
		in_item_t it;
		for (int i = 0; i < frame_buf.size(); i++) begin
			it.data_byte   = frame_buf[i];
			it.frame_start = (i == 0) ? lead_start : (scatter && $urandom_range(7) == 0);
			file_bytes.push_back(it);
		end
		bytes_queued += frame_buf.size();
		frame_buf.delete();
	endtask

	// up to two random bytes after an error, all to be ignored
	task automatic finish_broken();
		repeat ($urandom_range(2)) add_byte(8'($urandom_range(255)));
		ship_frame(1'b1, 1'b0);
	endtask

	task automatic add_field(input int idx, input int unsigned n, input flaw_t flaw,
			input int bad_field);
		if (idx == bad_field && flaw == FLAW_SIGN) begin
			add_byte($urandom_range(1) ? CH_PLUS : CH_MINUS);
			add_number(n);
		end else if (idx == bad_field && flaw == FLAW_OVERSIZE) begin
			add_number($urandom_range(9999, MAX_DIM + 1));
		end else if (idx == bad_field && flaw == FLAW_ZERO_DIM) begin
			repeat ($urandom_range(1, 2)) add_byte(CH_0);
		end else begin
			add_number(n);
		end
	endtask

	task automatic build_frame(input flaw_t flaw);
		int unsigned w;
		int unsigned h;
		int unsigned maxv;
		int unsigned npix;
		int          bad_field;
		logic [7:0]  junk;
		w         = $urandom_range(1, 5);
		h         = $urandom_range(1, 4);
		maxv      = MAXVAL_OK;
		bad_field = $urandom_range(flaw == FLAW_ZERO_DIM ? 1 : 2);

		if (flaw == FLAW_NOISE) begin
			repeat ($urandom_range(3, 8)) add_byte(8'($urandom_range(255)));
			ship_frame(1'b1, 1'b1);
			return;
		end
		if (flaw == FLAW_BAD_MAGIC) begin
			if ($urandom_range(1)) begin
				add_byte(CH_P);
				do
					junk = 8'($urandom_range(255));
				while (junk == CH_5);
			end else begin
				do
					junk = 8'($urandom_range(255));
				while (junk == CH_P);
			end
			add_byte(junk);
			finish_broken();
			return;
		end
		if (flaw == FLAW_HUGE_HEADER) begin
			w = MAX_DIM;
			h = MAX_DIM;
		end
		if (flaw == FLAW_BAD_MAXVAL) begin
			do
				maxv = $urandom_range(MAX_DIM);
			while (maxv == MAXVAL_OK);
		end

		add_text("P5");
		repeat ($urandom_range(2)) add_byte(pick_ws(1'b0));
		if ($urandom_range(2) == 0) begin
			// comment body may hold anything but a line end
			add_byte(CH_HASH);
			repeat ($urandom_range(4)) begin
				do
					junk = 8'($urandom_range(255));
				while (junk == CH_CR || junk == CH_LF);
				add_byte(junk);
			end
			add_byte($urandom_range(1) ? CH_CR : CH_LF);
			repeat ($urandom_range(1)) add_byte(pick_ws(1'b0));
		end

		// width, height, maxval with whitespace runs between them
		for (int idx = 0; idx < 3; idx++) begin
			add_field(idx, idx == 0 ? w : (idx == 1 ? h : maxv), flaw, bad_field);
			if (idx == 2)
				break;
			add_byte(pick_ws(1'b0));
			if ((flaw == FLAW_SIGN || flaw == FLAW_OVERSIZE || flaw == FLAW_ZERO_DIM) &&
					bad_field == idx) begin
				finish_broken();
				return;
			end
			if (idx == 0 && flaw == FLAW_LATE_COMMENT) begin
				add_byte(CH_HASH);
				finish_broken();
				return;
			end
			repeat ($urandom_range(1)) add_byte(pick_ws(1'b0));
		end

		// the single byte after maxval
		if (flaw == FLAW_VT_AFTER_MAXVAL) begin
			add_byte($urandom_range(1) ? CH_VT : CH_FF);
		end else if (flaw == FLAW_BAD_MAXVAL) begin
			do
				junk = 8'($urandom_range(255));
			while (is_dig(junk));
			add_byte(junk);
		end else begin
			add_byte(pick_ws(1'b1));
		end
		if (flaw != FLAW_NONE && flaw != FLAW_TRUNCATED && flaw != FLAW_HUGE_HEADER) begin
			finish_broken();
			return;
		end

		npix = w * h;
		if (flaw == FLAW_TRUNCATED)
			npix = $urandom_range(npix - 1);
		else if (flaw == FLAW_HUGE_HEADER)
			npix = $urandom_range(1, 3);
		repeat (npix) add_byte(8'($urandom_range(255)));
		// trailing bytes after a complete image are dropped by the block
		if (flaw == FLAW_NONE && $urandom_range(3) == 0)
			repeat ($urandom_range(1, 2)) add_byte(8'($urandom_range(255)));
		ship_frame(1'b1, 1'b0);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		int    target;
		int    mid;
		bit    paused;
		bit    border;
		flaw_t flaw;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: border on with black margin
		write_reg(REG_BORDER_ENABLE, 8'h01);
		write_reg(REG_MARGIN_SHADE, 8'h00);
		@(negedge clk);
		// 2x1 image, no frame start right after reset, comment closed by CR,
		// VT and FF as separators, pixels at both extremes
		add_text("P5#x");
		add_byte(CH_CR);
		add_text("2");
		add_byte(CH_VT);
		add_text("1");
		add_byte(CH_FF);
		add_text("255");
		add_byte(CH_LF);
		add_byte(8'h00);
		add_byte(8'hFF);
		ship_frame(1'b0, 1'b0);
		// largest legal dimensions: widest margin row, then cut short
		add_text("P54096 4096 255");
		add_byte(CH_TAB);
		add_byte(8'hA5);
		ship_frame(1'b1, 1'b0);
		// sign where the width should start
		add_text("P5-");
		ship_frame(1'b1, 1'b0);

		// Random: six batches over three idle profiles, registers rewritten
		// between batches while the block is quiet
		for (int b = 0; b < 6; b++) begin
			wait_quiet();
			case (b / 2)
				0: begin
					src_idle_pct = 36;
					rcv_idle_pct = 56;
				end
				1: begin
					src_idle_pct = 56;
					rcv_idle_pct = 36;
				end
				default: begin
					src_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			border = (b != 0 && b != 3);
			write_reg(REG_BORDER_ENABLE, {7'($urandom_range(127)), border});
			if (b < 2)
				write_reg(REG_MARGIN_SHADE, 8'd255);
			else if (b == 5)
				write_reg(REG_MARGIN_SHADE, 8'd0);
			else
				write_reg(REG_MARGIN_SHADE, 8'($urandom_range(255)));
			@(negedge clk);

			target = bytes_queued + BATCH_BYTES;
			mid    = bytes_queued + BATCH_BYTES / 2;
			paused = 1'b0;
			while (bytes_queued < target) begin
				// halfway through, hold the sender until every result is back
				if (!paused && bytes_queued >= mid) begin
					wait_quiet();
					paused = 1'b1;
				end
				if ($urandom_range(99) < 45) begin
					flaw = flaw_t'(flaw_turn % FLAW_KINDS + 1);
					flaw_turn++;
				end else begin
					flaw = FLAW_NONE;
				end
				build_frame(flaw);
			end
		end

		wait_quiet();
		$display("Sent %0d file bytes; checked %0d results: %0d headers, %0d format errors,",
			bytes_taken, results_seen, headers_seen, format_errors);
		$display("%0d maxval rejects; %0d register writes across three idle profiles.",
			maxval_rejects, reg_writes);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== pgm_p5_stream_deframer.f =====
hw/rtl/pgm_p5_pkg.sv
hw/rtl/pgm_p5_front.sv
hw/rtl/pgm_p5_cmdq.sv
hw/rtl/pgm_p5_back.sv
hw/rtl/pgm_p5_stream_deframer.sv
dv/tb_pgm_p5_stream_deframer.sv
